FILE: design/dmt_pkg.sv
// dmt_pkg: shared types and constants of the depth map mesh triangulator
// no dependencies; every other design file but dmt_stream_if refers to it by scoped names

package dmt_pkg;

  localparam int DEPTH_W    = 16;
  localparam int THR_W      = 16;
  localparam int IDX_W      = 20;
  localparam int CFG_SIZE_W = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int LIMIT_W    = 32;
  localparam int SCALED_W   = DEPTH_W + 8;
  localparam int SQ_W       = 2 * SCALED_W;

  localparam logic [CFG_SIZE_W-1:0] FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_SIZE_W-1:0] FRAME_HEIGHT_RESET = 11'd1024;
  localparam logic [THR_W-1:0]      THRESHOLD_RESET    = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic               first_of_frame;
  } pixel_t;

  typedef struct packed {
    logic             tri0_valid;
    logic [IDX_W-1:0] tri0_a;
    logic [IDX_W-1:0] tri0_b;
    logic [IDX_W-1:0] tri0_c;
    logic             tri1_valid;
    logic [IDX_W-1:0] tri1_a;
    logic [IDX_W-1:0] tri1_b;
    logic [IDX_W-1:0] tri1_c;
  } tri_pair_t;

  // upper-left, upper, left and current depth of one quad
  typedef struct packed {
    logic [DEPTH_W-1:0] d1;
    logic [DEPTH_W-1:0] d2;
    logic [DEPTH_W-1:0] d3;
    logic [DEPTH_W-1:0] d4;
  } quad_depth_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] diff;
    logic [LIMIT_W-1:0] limit;
  } edge_term_t;

  typedef struct packed {
    edge_term_t e12;
    edge_term_t e24;
    edge_term_t e13;
    edge_term_t e34;
    edge_term_t g14;
    edge_term_t g23;
  } quad_terms_t;

  typedef struct packed {
    logic            big;
    logic [SQ_W-1:0] sq_diff;
    logic [SQ_W-1:0] sq_limit;
  } diag_term_t;

  typedef struct packed {
    logic       e12;
    logic       e24;
    logic       e13;
    logic       e34;
    diag_term_t g14;
    diag_term_t g23;
  } quad_flags_t;

endpackage

FILE: design/dmt_stream_if.sv
// dmt_stream_if: valid/ready channel carrying one payload per transaction
// payload type set per instance, normally from dmt_pkg

interface dmt_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

FILE: design/depth_map_mesh_triangulator.sv
// depth_map_mesh_triangulator: top level, configuration registers and pipeline
// uses dmt_pkg, dmt_stream_if, dmt_scan, dmt_quad_test and dmt_tri_emit

// Takes one depth pixel per cycle in raster order, back-pressure allowing, and
// returns, for each 2x2 quad that has at least one triangle, a pair of triangles
// of vertex indices that pass the s1, s2 and s3 registers to the output register.
// Without back-pressure the sustained rate is one pixel per clock, set by the row
// store, a MAX_WIDTH x 16 memory that takes one write of the leaving pixel and
// one read ahead for the entering pixel each cycle. The row store needs no
// clearing pass after reset, so pixels are taken from the first cycle; start each
// frame with first_of_frame set. Quads with no triangle produce no transaction.
// Write the size and threshold registers only while no pixel is in flight.

module depth_map_mesh_triangulator #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dmt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  dmt_stream_if.sink                        pixels,
  dmt_stream_if.source                      triangles
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [dmt_pkg::CFG_SIZE_W-1:0] frame_width;
  logic [dmt_pkg::CFG_SIZE_W-1:0] frame_height;
  logic [dmt_pkg::THR_W-1:0]      threshold;
  logic [WW-1:0]                  width_eff;
  logic [HW-1:0]                  height_eff;

  logic                 s1_valid;
  logic                 s1_ready;
  dmt_pkg::quad_depth_t s1_depths;
  logic [CW-1:0]        s1_col;
  logic [RW-1:0]        s1_row;
  logic                 s1_quad;

  logic                      s3_valid;
  logic                      s3_ready;
  dmt_pkg::quad_flags_t      s3_flags;
  logic [CW-1:0]             s3_col;
  logic [dmt_pkg::IDX_W-1:0] s3_base_cur;
  logic [dmt_pkg::IDX_W-1:0] s3_base_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dmt_pkg::FRAME_WIDTH_RESET;
      frame_height <= dmt_pkg::FRAME_HEIGHT_RESET;
      threshold    <= dmt_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dmt_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[dmt_pkg::CFG_SIZE_W-1:0];
        dmt_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[dmt_pkg::CFG_SIZE_W-1:0];
        dmt_pkg::REG_THRESHOLD:    threshold    <= cfg_data[dmt_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // sizes clamped to the supported range
  always_comb begin
    if (frame_width < dmt_pkg::CFG_SIZE_W'(2)) begin
      width_eff = WW'(2);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(frame_width);
    end
    if (frame_height < dmt_pkg::CFG_SIZE_W'(2)) begin
      height_eff = HW'(2);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(frame_height);
    end
  end

  dmt_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .pixels     (pixels),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_depths  (s1_depths),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_quad    (s1_quad)
  );

  dmt_quad_test #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_quad_test (
    .clk         (clk),
    .rst         (rst),
    .width_eff   (width_eff),
    .threshold   (threshold),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_depths   (s1_depths),
    .s1_col      (s1_col),
    .s1_row      (s1_row),
    .s1_quad     (s1_quad),
    .s3_valid    (s3_valid),
    .s3_ready    (s3_ready),
    .s3_flags    (s3_flags),
    .s3_col      (s3_col),
    .s3_base_cur (s3_base_cur),
    .s3_base_up  (s3_base_up)
  );

  dmt_tri_emit #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_tri_emit (
    .clk         (clk),
    .rst         (rst),
    .s3_valid    (s3_valid),
    .s3_ready    (s3_ready),
    .s3_flags    (s3_flags),
    .s3_col      (s3_col),
    .s3_base_cur (s3_base_cur),
    .s3_base_up  (s3_base_up),
    .triangles   (triangles)
  );

endmodule

FILE: design/dmt_scan.sv
// dmt_scan: raster counters, row store memory, left and upper-left samples
// first pipeline stage; uses dmt_pkg and the dmt_stream_if pixel channel

module dmt_scan #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height_eff,
  dmt_stream_if.sink                      pixels,
  output logic                            s1_valid,
  input  logic                            s1_ready,
  output dmt_pkg::quad_depth_t            s1_depths,
  output logic [$clog2(MAX_WIDTH)-1:0]    s1_col,
  output logic [$clog2(MAX_HEIGHT)-1:0]   s1_row,
  output logic                            s1_quad
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [dmt_pkg::DEPTH_W-1:0] row_store [MAX_WIDTH];
  logic [dmt_pkg::DEPTH_W-1:0] upper_data;
  logic [dmt_pkg::DEPTH_W-1:0] left_depth;
  logic [dmt_pkg::DEPTH_W-1:0] upper_left;
  logic [dmt_pkg::DEPTH_W-1:0] s1_d4;
  logic [CW-1:0]               column_count;
  logic [RW-1:0]               row_count;
  logic [CW-1:0]               col_cur;
  logic [RW-1:0]               row_cur;
  logic [CW:0]                 col_inc;
  logic [RW:0]                 row_inc;
  logic [CW-1:0]               column_count_next;
  logic [RW-1:0]               row_count_next;
  logic                        accept;
  logic                        s1_take;

  assign pixels.ready = !s1_valid || s1_ready;
  assign accept       = pixels.valid && pixels.ready;
  assign s1_take      = s1_valid && s1_ready;

  assign col_cur = pixels.payload.first_of_frame ? '0 : column_count;
  assign row_cur = pixels.payload.first_of_frame ? '0 : row_count;
  assign col_inc = {1'b0, col_cur} + (CW+1)'(1);
  assign row_inc = {1'b0, row_cur} + (RW+1)'(1);

  always_comb begin
    column_count_next = col_inc[CW-1:0];
    row_count_next    = row_cur;
    if (col_inc >= width_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= height_eff) ? '0 : row_inc[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
      left_depth   <= '0;
      upper_left   <= '0;
    end else begin
      if (pixels.ready) begin
        s1_valid <= pixels.valid;
      end
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (s1_take) begin
        left_depth <= s1_d4;
        upper_left <= upper_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_d4   <= pixels.payload.depth;
      s1_col  <= col_cur;
      s1_row  <= row_cur;
      s1_quad <= (col_cur != '0) && (row_cur != '0);
    end
  end

  // row store: one write of the leaving pixel, one read ahead for the entering one
  always_ff @(posedge clk) begin
    if (s1_take) begin
      row_store[s1_col] <= s1_d4;
    end
    if (accept) begin
      upper_data <= (s1_take && (s1_col == col_cur)) ? s1_d4 : row_store[col_cur];
    end
  end

  assign s1_depths = '{d1: upper_left, d2: upper_data, d3: left_depth, d4: s1_d4};

endmodule

FILE: design/dmt_quad_test.sv
// dmt_quad_test: scaled depth differences, limits, edge tests and diagonal squares
// second and third pipeline stages; uses dmt_pkg

module dmt_quad_test #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
  input  logic [dmt_pkg::THR_W-1:0]         threshold,
  input  logic                              s1_valid,
  output logic                              s1_ready,
  input  dmt_pkg::quad_depth_t              s1_depths,
  input  logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
  input  logic [$clog2(MAX_HEIGHT)-1:0]     s1_row,
  input  logic                              s1_quad,
  output logic                              s3_valid,
  input  logic                              s3_ready,
  output dmt_pkg::quad_flags_t              s3_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]      s3_col,
  output logic [dmt_pkg::IDX_W-1:0]         s3_base_cur,
  output logic [dmt_pkg::IDX_W-1:0]         s3_base_up
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = RW + WW;

  logic                              s2_valid;
  dmt_pkg::quad_terms_t              s2_terms;
  logic [CW-1:0]                     s2_col;
  logic [dmt_pkg::IDX_W-1:0]         s2_base_cur;
  dmt_pkg::quad_terms_t              terms;
  dmt_pkg::quad_flags_t              flags;
  logic [PW-1:0]                     row_prod;
  logic                              s3_free;

  function automatic dmt_pkg::edge_term_t edge_terms(
    input logic [dmt_pkg::DEPTH_W-1:0] a,
    input logic [dmt_pkg::DEPTH_W-1:0] b,
    input logic [dmt_pkg::THR_W-1:0]   thr
  );
    dmt_pkg::edge_term_t       t;
    logic [dmt_pkg::DEPTH_W-1:0] nearer;
    t.diff = (a > b) ? (a - b) : (b - a);
    nearer = (a < b) ? a : b;
    if (nearer == '0) begin
      nearer = dmt_pkg::DEPTH_W'(1);
    end
    t.limit = dmt_pkg::LIMIT_W'(thr) * dmt_pkg::LIMIT_W'(nearer);
    return t;
  endfunction

  function automatic logic edge_short(input dmt_pkg::edge_term_t t);
    return dmt_pkg::LIMIT_W'({t.diff, 8'd0}) < t.limit;
  endfunction

  function automatic dmt_pkg::diag_term_t diag_terms(input dmt_pkg::edge_term_t t);
    dmt_pkg::diag_term_t          g;
    logic [dmt_pkg::SCALED_W-1:0] scaled;
    logic [dmt_pkg::SCALED_W-1:0] lim;
    scaled     = {t.diff, 8'd0};
    lim        = t.limit[dmt_pkg::SCALED_W-1:0];
    g.big      = t.limit[dmt_pkg::LIMIT_W-1:dmt_pkg::SCALED_W] != '0;
    g.sq_diff  = dmt_pkg::SQ_W'(scaled) * dmt_pkg::SQ_W'(scaled);
    g.sq_limit = dmt_pkg::SQ_W'(lim) * dmt_pkg::SQ_W'(lim);
    return g;
  endfunction

  assign s3_free  = !s3_valid || s3_ready;
  assign s1_ready = !s2_valid || s3_free;

  always_comb begin
    terms.e12 = edge_terms(s1_depths.d1, s1_depths.d2, threshold);
    terms.e24 = edge_terms(s1_depths.d2, s1_depths.d4, threshold);
    terms.e13 = edge_terms(s1_depths.d1, s1_depths.d3, threshold);
    terms.e34 = edge_terms(s1_depths.d3, s1_depths.d4, threshold);
    terms.g14 = edge_terms(s1_depths.d1, s1_depths.d4, threshold);
    terms.g23 = edge_terms(s1_depths.d2, s1_depths.d3, threshold);
  end

  assign row_prod = PW'(s1_row) * PW'(width_eff);

  always_comb begin
    flags.e12 = edge_short(s2_terms.e12);
    flags.e24 = edge_short(s2_terms.e24);
    flags.e13 = edge_short(s2_terms.e13);
    flags.e34 = edge_short(s2_terms.e34);
    flags.g14 = diag_terms(s2_terms.g14);
    flags.g23 = diag_terms(s2_terms.g23);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s2_valid <= s1_valid && s1_quad;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s2_terms    <= terms;
      s2_col      <= s1_col;
      s2_base_cur <= dmt_pkg::IDX_W'(row_prod);
    end
    if (s3_free) begin
      s3_flags    <= flags;
      s3_col      <= s2_col;
      s3_base_cur <= s2_base_cur;
      s3_base_up  <= s2_base_cur - dmt_pkg::IDX_W'(width_eff);
    end
  end

endmodule

FILE: design/dmt_tri_emit.sv
// dmt_tri_emit: diagonal choice, triangle selection and output register
// last pipeline stage; uses dmt_pkg and the dmt_stream_if triangle channel

module dmt_tri_emit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s3_valid,
  output logic                         s3_ready,
  input  dmt_pkg::quad_flags_t         s3_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0] s3_col,
  input  logic [dmt_pkg::IDX_W-1:0]    s3_base_cur,
  input  logic [dmt_pkg::IDX_W-1:0]    s3_base_up,
  dmt_stream_if.source                 triangles
);

  logic                      out_valid;
  dmt_pkg::tri_pair_t        out_data;
  dmt_pkg::tri_pair_t        result;
  logic [dmt_pkg::IDX_W-1:0] col_x;
  logic [dmt_pkg::IDX_W-1:0] i1;
  logic [dmt_pkg::IDX_W-1:0] i2;
  logic [dmt_pkg::IDX_W-1:0] i3;
  logic [dmt_pkg::IDX_W-1:0] i4;
  logic                      diag14;
  logic                      diag23;
  logic                      has_result;
  logic                      load;

  assign col_x = dmt_pkg::IDX_W'(s3_col);
  assign i1    = s3_base_up + col_x - dmt_pkg::IDX_W'(1);
  assign i2    = s3_base_up + col_x;
  assign i3    = s3_base_cur + col_x - dmt_pkg::IDX_W'(1);
  assign i4    = s3_base_cur + col_x;

  // diagonal limit scaled by root two, compared as squares
  assign diag14 = s3_flags.g14.big ||
                  ({1'b0, s3_flags.g14.sq_diff} < {s3_flags.g14.sq_limit, 1'b0});
  assign diag23 = s3_flags.g23.big ||
                  ({1'b0, s3_flags.g23.sq_diff} < {s3_flags.g23.sq_limit, 1'b0});

  always_comb begin
    result = '0;
    if (diag14) begin
      if (s3_flags.e12 && s3_flags.e24) begin
        result.tri0_valid = 1'b1;
        result.tri0_a     = i1;
        result.tri0_b     = i4;
        result.tri0_c     = i2;
      end
      if (s3_flags.e13 && s3_flags.e34) begin
        result.tri1_valid = 1'b1;
        result.tri1_a     = i1;
        result.tri1_b     = i3;
        result.tri1_c     = i4;
      end
    end else if (diag23) begin
      if (s3_flags.e12 && s3_flags.e13) begin
        result.tri0_valid = 1'b1;
        result.tri0_a     = i1;
        result.tri0_b     = i3;
        result.tri0_c     = i2;
      end
      if (s3_flags.e24 && s3_flags.e34) begin
        result.tri1_valid = 1'b1;
        result.tri1_a     = i3;
        result.tri1_b     = i4;
        result.tri1_c     = i2;
      end
    end
  end

  assign has_result = result.tri0_valid || result.tri1_valid;
  assign s3_ready   = !out_valid || triangles.ready || !has_result;
  assign load       = s3_valid && s3_ready && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (triangles.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  assign triangles.valid   = out_valid;
  assign triangles.payload = out_data;

endmodule

FILE: test/tb_depth_map_mesh_triangulator.sv
// tb_depth_map_mesh_triangulator: self-checking testbench for the depth map mesh triangulator
// drives pixels and register writes, predicts triangle pairs and checks every transaction
// depends on dmt_pkg, dmt_stream_if and depth_map_mesh_triangulator
`timescale 1ns / 100ps

module tb_depth_map_mesh_triangulator;

  localparam int LINE_MAX    = 1024;
  localparam int SIZE_MAX    = 1024;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [dmt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dmt_pkg::CFG_DATA_W-1:0] cfg_data;

  dmt_stream_if #(.payload_t(dmt_pkg::pixel_t))    pixels_if ();
  dmt_stream_if #(.payload_t(dmt_pkg::tri_pair_t)) tris_if ();

  depth_map_mesh_triangulator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels_if),
    .triangles (tris_if)
  );

  // predictor state
  int               width_reg  = dmt_pkg::FRAME_WIDTH_RESET;
  int               height_reg = dmt_pkg::FRAME_HEIGHT_RESET;
  int               thr_reg    = dmt_pkg::THRESHOLD_RESET;
  logic [dmt_pkg::DEPTH_W-1:0] line_buf [LINE_MAX];
  logic [dmt_pkg::DEPTH_W-1:0] left_px  = '0;
  logic [dmt_pkg::DEPTH_W-1:0] upleft_px = '0;
  int               col_cnt = 0;
  int               row_cnt = 0;

  dmt_pkg::tri_pair_t expected_tris [$];
  int        errors    = 0;
  int        cycles    = 0;
  int        sink_hold = 0;
  bit        quiet     = 0;

  string field_names [8] = '{"tri0_valid", "tri0_a", "tri0_b", "tri0_c",
                             "tri1_valid", "tri1_a", "tri1_b", "tri1_c"};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("depth_map_mesh_triangulator test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int size_in_use(input int v);
    if (v < 2) return 2;
    if (v > SIZE_MAX) return SIZE_MAX;
    return v;
  endfunction

  function automatic longint unsigned scaled_diff(input logic [dmt_pkg::DEPTH_W-1:0] a,
                                                  input logic [dmt_pkg::DEPTH_W-1:0] b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * 256;
  endfunction

  function automatic longint unsigned scaled_limit(input logic [dmt_pkg::DEPTH_W-1:0] a,
                                                   input logic [dmt_pkg::DEPTH_W-1:0] b);
    longint unsigned nearer;
    nearer = (a < b) ? a : b;
    if (nearer == 0) nearer = 1;
    return longint'(thr_reg) * nearer;
  endfunction

  function automatic bit short_edge(input logic [dmt_pkg::DEPTH_W-1:0] a,
                                    input logic [dmt_pkg::DEPTH_W-1:0] b);
    return scaled_diff(a, b) < scaled_limit(a, b);
  endfunction

  // diagonal limit is threshold times root two, compared as squares
  function automatic bit short_diag(input logic [dmt_pkg::DEPTH_W-1:0] a,
                                    input logic [dmt_pkg::DEPTH_W-1:0] b);
    longint unsigned l, r;
    l = scaled_diff(a, b);
    r = scaled_limit(a, b);
    if (r >= (64'd1 << 24)) return 1'b1;
    return (l * l) < (2 * r * r);
  endfunction

  task automatic predict_pixel(input logic [dmt_pkg::DEPTH_W-1:0] d4, input logic fof);
    int w, h, col, row, i1, i2, i3, i4;
    logic [dmt_pkg::DEPTH_W-1:0] d1, d2, d3;
    bit e12, e24, e13, e34;
    dmt_pkg::tri_pair_t t;
    w = size_in_use(width_reg);
    h = size_in_use(height_reg);
    if (fof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    col = col_cnt % LINE_MAX;
    row = row_cnt;
    d1 = upleft_px;
    d2 = line_buf[col];
    d3 = left_px;
    if (row > 0 && col > 0) begin
      i1 = (row - 1) * w + col - 1;
      i2 = (row - 1) * w + col;
      i3 = row * w + col - 1;
      i4 = row * w + col;
      e12 = short_edge(d1, d2);
      e24 = short_edge(d2, d4);
      e13 = short_edge(d1, d3);
      e34 = short_edge(d3, d4);
      t = '0;
      if (short_diag(d1, d4)) begin
        if (e12 && e24) begin
          t.tri0_valid = 1'b1;
          t.tri0_a = dmt_pkg::IDX_W'(i1);
          t.tri0_b = dmt_pkg::IDX_W'(i4);
          t.tri0_c = dmt_pkg::IDX_W'(i2);
        end
        if (e13 && e34) begin
          t.tri1_valid = 1'b1;
          t.tri1_a = dmt_pkg::IDX_W'(i1);
          t.tri1_b = dmt_pkg::IDX_W'(i3);
          t.tri1_c = dmt_pkg::IDX_W'(i4);
        end
      end else if (short_diag(d2, d3)) begin
        if (e12 && e13) begin
          t.tri0_valid = 1'b1;
          t.tri0_a = dmt_pkg::IDX_W'(i1);
          t.tri0_b = dmt_pkg::IDX_W'(i3);
          t.tri0_c = dmt_pkg::IDX_W'(i2);
        end
        if (e24 && e34) begin
          t.tri1_valid = 1'b1;
          t.tri1_a = dmt_pkg::IDX_W'(i3);
          t.tri1_b = dmt_pkg::IDX_W'(i4);
          t.tri1_c = dmt_pkg::IDX_W'(i2);
        end
      end
      if (t.tri0_valid || t.tri1_valid) expected_tris = {expected_tris, t};
    end
    upleft_px = d2;
    line_buf[col] = d4;
    left_px = d4;
    col = col_cnt + 1;
    if (col >= w) begin
      col = 0;
      row = row_cnt + 1;
      if (row >= h) row = 0;
      row_cnt = row;
    end
    col_cnt = col;
  endtask

  task automatic check_tris(input dmt_pkg::tri_pair_t got);
    dmt_pkg::tri_pair_t want;
    logic [dmt_pkg::IDX_W-1:0] g [8];
    logic [dmt_pkg::IDX_W-1:0] e [8];
    if (expected_tris.size() == 0) begin
      report_mismatch("unexpected triangle transaction");
      return;
    end
    want = expected_tris.pop_front();
    g = '{dmt_pkg::IDX_W'(got.tri0_valid), got.tri0_a, got.tri0_b, got.tri0_c,
          dmt_pkg::IDX_W'(got.tri1_valid), got.tri1_a, got.tri1_b, got.tri1_c};
    e = '{dmt_pkg::IDX_W'(want.tri0_valid), want.tri0_a, want.tri0_b, want.tri0_c,
          dmt_pkg::IDX_W'(want.tri1_valid), want.tri1_a, want.tri1_b, want.tri1_c};
    for (int k = 0; k < 8; k++) begin
      if (g[k] !== e[k])
        report_mismatch($sformatf("%s got %0d expected %0d", field_names[k], g[k], e[k]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && tris_if.valid && tris_if.ready) begin
      check_tris(tris_if.payload);
      sink_hold = quiet ? 0 : $urandom_range(0, 4);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      tris_if.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      tris_if.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      tris_if.ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_pixel(input logic [dmt_pkg::DEPTH_W-1:0] d, input logic fof);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      pixels_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixels_if.valid <= 1'b1;
    pixels_if.payload <= {d, fof};
    @(posedge clk);
    while (!pixels_if.ready) @(posedge clk);
    predict_pixel(d, fof);
    @(negedge clk);
  endtask

  task automatic wait_results();
    pixels_if.valid <= 1'b0;
    while (expected_tris.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input dmt_pkg::cfg_reg_t idx, input int v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[dmt_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    case (idx)
      dmt_pkg::REG_FRAME_WIDTH:  width_reg  = v & 'h7FF;
      dmt_pkg::REG_FRAME_HEIGHT: height_reg = v & 'h7FF;
      dmt_pkg::REG_THRESHOLD:    thr_reg    = v & 'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_frame(input int w, input int h, input int t);
    wait_results();
    repeat (SETTLE) @(negedge clk);
    write_reg(dmt_pkg::REG_FRAME_WIDTH, w);
    write_reg(dmt_pkg::REG_FRAME_HEIGHT, h);
    write_reg(dmt_pkg::REG_THRESHOLD, t);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [dmt_pkg::DEPTH_W-1:0] pick_depth(input int base, input int spread);
    int v;
    case ($urandom_range(0, 19))
      0: v = 0;
      1: v = 65535;
      2: v = $urandom_range(0, 65535);
      3: v = base + $urandom_range(0, 4 * spread + 64);
      default: v = base + $urandom_range(0, spread);
    endcase
    if (v > 65535) v = 65535;
    return v[dmt_pkg::DEPTH_W-1:0];
  endfunction

  // one phase of raster pixels from a smooth surface with occasional jumps
  task automatic run_frame(input int w, input int h, input int t, input int n,
                           input bit noise, input int pause_at);
    int base, spread;
    longint s;
    logic fof;
    set_frame(w, h, t);
    case ($urandom_range(0, 3))
      0: base = $urandom_range(0, 20);
      1: base = $urandom_range(100, 2000);
      2: base = $urandom_range(2000, 40000);
      default: base = $urandom_range(40000, 65535);
    endcase
    s = (longint'(base) * t) / 1024;
    if (s < 1) s = 1;
    if (s > 65535) s = 65535;
    spread = int'(s);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        wait_results();
        @(negedge clk);
      end
      fof = (i == 0) || (noise && $urandom_range(0, 63) == 0);
      send_pixel(pick_depth(base, spread), fof);
    end
  endtask

  // 2x2 frames, one quad each: both diagonals, lone triangles, none, zero and full depth
  task automatic test_directed_quads();
    logic [dmt_pkg::DEPTH_W-1:0] q [6][4];
    q = '{'{16'd1000, 16'd1000, 16'd1000, 16'd1000},
          '{16'd0,    16'd0,    16'd0,    16'd0},
          '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
          '{16'd1000, 16'd1000, 16'd1000, 16'd5000},
          '{16'd1000, 16'd9000, 16'd1000, 16'd1000},
          '{16'd0,    16'd65535, 16'd65535, 16'd0}};
    quiet = 1'b1;
    set_frame(2, 2, 256);
    for (int f = 0; f < 6; f++)
      for (int p = 0; p < 4; p++)
        send_pixel(q[f][p], p == 0);
    quiet = 1'b0;
  endtask

  task automatic test_threshold_extremes();
    run_frame(0, 3, 0, 20, 0, -1);
    run_frame(5, 1, 65535, 30, 0, -1);
    run_frame(3, 4, 1, 30, 0, -1);
  endtask

  task automatic test_wide_row();
    run_frame('hFFFF, 2, 300, SIZE_MAX + 48, 0, -1);
  endtask

  task automatic test_tall_frame();
    run_frame(0, 2047, 400, 100, 0, -1);
  endtask

  // shrinking the size mid-frame wraps counters that are past the new limits
  task automatic test_shrink_mid_frame();
    run_frame(8, 6, 256, 29, 0, -1);
    set_frame(4, 3, 256);
    for (int i = 0; i < 30; i++) send_pixel(pick_depth(1000, 250), 1'b0);
  endtask

  task automatic test_random_frames();
    int sent, w_reg, h_reg, t_reg, w, h, n, pause_at;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < 200) begin
      case ($urandom_range(0, 9))
        0: w_reg = $urandom_range(0, 1);
        1: w_reg = $urandom_range(13, 40);
        default: w_reg = $urandom_range(2, 12);
      endcase
      h_reg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      case ($urandom_range(0, 7))
        0: t_reg = 0;
        1: t_reg = 65535;
        2: t_reg = $urandom_range(0, 65535);
        3: t_reg = 256;
        default: t_reg = $urandom_range(128, 1024);
      endcase
      w = size_in_use(w_reg);
      h = size_in_use(h_reg);
      n = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
      pause_at = -1;
      if (!paused && sent + n > 100) begin
        pause_at = $urandom_range(1, n - 1);
        paused = 1;
      end
      quiet = ($urandom_range(0, 3) == 0);
      run_frame(w_reg, h_reg, t_reg, n, 1, pause_at);
      sent += n;
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = dmt_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    pixels_if.valid = 1'b0;
    pixels_if.payload = '0;
    tris_if.ready = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_quads();
    test_threshold_extremes();
    test_shrink_mid_frame();
    test_wide_row();
    test_tall_frame();
    test_random_frames();

    wait_results();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("depth_map_mesh_triangulator test passed");
    end else begin
      $display("depth_map_mesh_triangulator test failed");
    end
    $finish;
  end

endmodule
